// ===== design/avclp_pkg.sv =====
// Shared types and constants for the length-prefix to start-code converter.
package avclp_pkg;

  // Result kinds as they appear on the output channel
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_DISCARD   = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_e;

  // Work the back end carries out for one accepted input byte
  typedef enum logic [1:0] {
    CMD_START       = 2'd0,  // start code 00 00 00 01
    CMD_DATA        = 2'd1,  // one payload byte
    CMD_DATA_STATUS = 2'd2,  // final payload byte, then status
    CMD_STATUS      = 2'd3   // status only
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [7:0]  data;
    kind_e       status;
  } cmd_t;

  localparam logic [2:0] LenBytesReset = 3'd4;
  localparam logic [2:0] LenBytesMin   = 3'd1;
  localparam logic [2:0] LenBytesMax   = 3'd4;
  localparam logic [7:0] PacketTypeNal = 8'd1;
  localparam logic [1:0] HeaderLast    = 2'd3;
  localparam logic [1:0] StartCodeLast = 2'd3;
  localparam logic [7:0] StartCodeEnd  = 8'h01;

endpackage

// ===== design/avclp_front.sv =====
// Packet parser: tracks header, length and payload phases and issues commands.
module avclp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_wdata_i,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic                push_o,
  output avclp_pkg::cmd_t     cmd_o
);
  import avclp_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DROP    = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  header_count_q, header_count_d;
  logic        type_ok_q, type_ok_d;
  logic [2:0]  length_count_q, length_count_d;
  logic [31:0] length_accum_q, length_accum_d;
  logic [31:0] payload_left_q, payload_left_d;
  logic [2:0]  len_bytes_q;

  logic [2:0]  eff_len;
  logic [31:0] accum_new;
  logic [2:0]  count_new;
  logic [31:0] payload_dec;
  logic        type_now;
  logic        emit;
  logic        status;

  // Clamp the configured prefix size into its legal range
  always_comb begin
    if (len_bytes_q < LenBytesMin) begin
      eff_len = LenBytesMin;
    end else if (len_bytes_q > LenBytesMax) begin
      eff_len = LenBytesMax;
    end else begin
      eff_len = len_bytes_q;
    end
  end

  assign accum_new   = {length_accum_q[23:0], in_byte_i};
  assign count_new   = length_count_q + 3'd1;
  assign payload_dec = payload_left_q - 32'd1;
  assign type_now    = (header_count_q == 2'd0) ? (in_byte_i == PacketTypeNal) : type_ok_q;

  // Classify the byte and pick the next phase
  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    type_ok_d      = type_ok_q;
    length_count_d = length_count_q;
    length_accum_d = length_accum_q;
    payload_left_d = payload_left_q;
    emit           = 1'b0;
    status         = 1'b0;
    cmd_o.op       = CMD_STATUS;
    cmd_o.data     = in_byte_i;
    cmd_o.status   = KIND_DONE;

    unique case (phase_q)
      PH_HEADER: begin
        type_ok_d = type_now;
        if (header_count_q != HeaderLast) begin
          header_count_d = header_count_q + 2'd1;
          if (in_last_i) begin
            emit         = 1'b1;
            status       = 1'b1;
            cmd_o.status = KIND_MALFORMED;
          end
        end else if (in_last_i) begin
          emit         = 1'b1;
          status       = 1'b1;
          cmd_o.status = type_now ? KIND_DONE : KIND_DISCARD;
        end else begin
          phase_d        = type_now ? PH_LENGTH : PH_DROP;
          length_count_d = 3'd0;
          length_accum_d = 32'd0;
        end
      end
      PH_LENGTH: begin
        length_accum_d = accum_new;
        length_count_d = count_new;
        if (count_new >= eff_len) begin
          if (accum_new == 32'd0) begin
            if (in_last_i) begin
              emit         = 1'b1;
              status       = 1'b1;
              cmd_o.status = KIND_DONE;
            end else begin
              phase_d = PH_DROP;
            end
          end else if (in_last_i) begin
            emit         = 1'b1;
            status       = 1'b1;
            cmd_o.status = KIND_MALFORMED;
          end else begin
            emit           = 1'b1;
            cmd_o.op       = CMD_START;
            payload_left_d = accum_new;
            phase_d        = PH_PAYLOAD;
          end
        end else if (in_last_i) begin
          emit         = 1'b1;
          status       = 1'b1;
          cmd_o.status = KIND_MALFORMED;
        end
      end
      PH_PAYLOAD: begin
        emit           = 1'b1;
        payload_left_d = payload_dec;
        if (in_last_i) begin
          status       = 1'b1;
          cmd_o.op     = CMD_DATA_STATUS;
          cmd_o.status = (payload_dec == 32'd0) ? KIND_DONE : KIND_MALFORMED;
        end else begin
          cmd_o.op = CMD_DATA;
          if (payload_dec == 32'd0) begin
            phase_d        = PH_LENGTH;
            length_count_d = 3'd0;
            length_accum_d = 32'd0;
          end
        end
      end
      PH_DROP: begin
        if (in_last_i) begin
          emit         = 1'b1;
          status       = 1'b1;
          cmd_o.status = type_ok_q ? KIND_DONE : KIND_DISCARD;
        end
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    // Return to the start of a packet after any status
    if (status) begin
      phase_d        = PH_HEADER;
      header_count_d = 2'd0;
      type_ok_d      = 1'b0;
      length_count_d = 3'd0;
      length_accum_d = 32'd0;
      payload_left_d = 32'd0;
    end
  end

  assign push_o = accept_i && emit;

  // Hold parser state and the prefix size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      header_count_q <= 2'd0;
      type_ok_q      <= 1'b0;
      length_count_q <= 3'd0;
      length_accum_q <= 32'd0;
      payload_left_q <= 32'd0;
      len_bytes_q    <= LenBytesReset;
    end else begin
      if (cfg_we_i) begin
        len_bytes_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q        <= phase_d;
        header_count_q <= header_count_d;
        type_ok_q      <= type_ok_d;
        length_count_q <= length_count_d;
        length_accum_q <= length_accum_d;
        payload_left_q <= payload_left_d;
      end
    end
  end

  // Payload phase always has bytes left to copy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> payload_left_q != 32'd0)
    else $error("payload phase with no bytes left");

endmodule

// ===== design/avclp_queue.sv =====
// Small command queue between the parser and the result expander.
module avclp_queue #(
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  avclp_pkg::cmd_t     push_data_i,
  input  logic                pop_i,
  output avclp_pkg::cmd_t     head_o,
  output logic                empty_o,
  output logic                full_o
);
  import avclp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  cmd_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFull);
  assign head_o  = entries_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrOne;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrOne;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntOne;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntOne;
      end
    end
  end

  // No push into a full queue, no pop from an empty one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("queue overflow or underflow");

endmodule

// ===== design/avclp_back.sv =====
// Result expander: turns queued commands into output transactions.
module avclp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  avclp_pkg::cmd_t     head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic [7:0]          out_byte_o,
  output logic [1:0]          kind_o,
  output logic                out_last_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);
  import avclp_pkg::*;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  kind_e      out_kind_q;
  logic       out_last_q;
  logic [1:0] step_q;

  logic       load;
  logic [7:0] res_byte;
  kind_e      res_kind;
  logic       res_last;

  assign load = (!out_valid_q || out_ready_i) && !empty_i;

  // Pick the result for the current step of the head command
  always_comb begin
    res_byte = 8'd0;
    res_kind = KIND_DATA;
    res_last = 1'b1;
    unique case (head_i.op)
      CMD_START: begin
        res_last = (step_q == StartCodeLast);
        res_byte = res_last ? StartCodeEnd : 8'd0;
      end
      CMD_DATA: begin
        res_byte = head_i.data;
      end
      CMD_DATA_STATUS: begin
        if (step_q == 2'd0) begin
          res_byte = head_i.data;
          res_last = 1'b0;
        end else begin
          res_kind = head_i.status;
        end
      end
      CMD_STATUS: begin
        res_kind = head_i.status;
      end
      default: begin
        res_kind = head_i.status;
      end
    endcase
  end

  assign pop_o = load && res_last;

  // Hold the output register and the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        step_q      <= res_last ? 2'd0 : step_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
      out_last_q <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign kind_o      = out_kind_q;
  assign out_last_o  = out_last_q;

  // A status result always closes the results of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q != KIND_DATA |-> out_last_q && out_byte_q == 8'd0)
    else $error("status result not last or carries data");

  // Mid-command steps only occur on multi-result commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 2'd0 |-> !empty_i && (head_i.op == CMD_START || head_i.op == CMD_DATA_STATUS))
    else $error("step counter out of sync with head command");

endmodule

// ===== design/avc_length_prefix_to_start_code.sv =====
// Top level of the length-prefix to start-code converter.
// Converts one length-prefixed AVC video packet per packet of input bytes into a
// start-code byte stream: each NAL length prefix (1 to 4 bytes, set by cfg_wdata_i)
// becomes 00 00 00 01, payload bytes pass through, and one status result (done,
// discarded or malformed) closes each packet. An input byte is accepted every cycle
// while the command queue has room; the output side delivers one result per cycle
// while out_ready_i is high, so a length prefix that yields a start code gives
// four results and a final payload byte two. Sustained payload input is one byte
// per cycle while out_ready_i is high, set by the single-result-per-cycle output
// register; start-code bursts fill the QueueDepth-entry queue before input stalls.
module avc_length_prefix_to_start_code #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       out_last_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);
  import avclp_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic empty;
  logic full;
  cmd_t cmd;
  cmd_t head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  avclp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  avclp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  avclp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_byte_o (out_byte_o),
    .kind_o     (kind_o),
    .out_last_o (out_last_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

endmodule
